/* design/hpt_pkg.sv */
// Package for the hysteresis peak tracker.
// Holds default sizes, fixed field widths, reset values and the status,
// operation and register index codes. No dependencies.
package hpt_pkg;

  // Defaults for the top-level parameters
  localparam int PEAK_DEPTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int TIME_BITS_DEF   = 16;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int ELAPSED_W = 16;
  localparam int HYST_W    = 11;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam int HYST_RST      = 30;
  localparam int START_POS_RST = 100;
  localparam int START_NEG_RST = -100;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 3'd0,
    ST_NEW     = 3'd1,
    ST_EXTEND  = 3'd2,
    ST_FULL    = 3'd3,
    ST_READ    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HYST      = 2'd0,
    CFG_START_POS = 2'd1,
    CFG_START_NEG = 2'd2
  } cfg_reg_t;

  // Control part of a result on its way to the output register
  typedef struct packed {
    status_t status;
    logic    rd_hit;   // read reply comes from the store, else zeros
  } res_ctl_t;

endpackage

/* design/hpt_if.sv */
// Valid/ready channel interfaces for the peak tracker: input items and results.
// Depends on hpt_pkg.
interface hpt_in_if import hpt_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int IDX_W       = $clog2(PEAK_DEPTH_DEF)
);
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               operation;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [ELAPSED_W-1:0]          elapsed;
  logic [IDX_W-1:0]              read_index;

  modport source (output valid, operation, sample, elapsed, read_index, input ready);
  modport sink   (input valid, operation, sample, elapsed, read_index, output ready);
endinterface

interface hpt_out_if import hpt_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int IDX_W       = $clog2(PEAK_DEPTH_DEF),
  parameter int CNT_W       = $clog2(PEAK_DEPTH_DEF + 1)
);
  logic                          valid;
  logic                          ready;
  logic [STATUS_W-1:0]           status;
  logic [IDX_W-1:0]              peak_index;
  logic signed [SAMPLE_BITS-1:0] peak_value;
  logic [TIME_BITS-1:0]          peak_time;
  logic                          peak_positive;
  logic [CNT_W-1:0]              peak_count;

  modport source (output valid, status, peak_index, peak_value, peak_time,
                  peak_positive, peak_count, input ready);
  modport sink   (input valid, status, peak_index, peak_value, peak_time,
                  peak_positive, peak_count, output ready);
endinterface

/* design/hpt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module hpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/hpt_tracker.sv */
// Peak tracking core: configuration registers, current peak registers and
// the per-item decision; issues store writes and read requests.
// Depends on hpt_pkg.
module hpt_tracker import hpt_pkg::*; #(
  parameter int PEAK_DEPTH  = PEAK_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  localparam int IDX_W      = $clog2(PEAK_DEPTH),
  localparam int CNT_W      = $clog2(PEAK_DEPTH + 1),
  localparam int CFG_W      = (SAMPLE_BITS > HYST_W) ? SAMPLE_BITS : HYST_W,
  localparam int ENTRY_W    = 1 + TIME_BITS + SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  // accepted item
  input  logic                          take,
  input  logic [OP_W-1:0]               operation,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [ELAPSED_W-1:0]          elapsed,
  input  logic [IDX_W-1:0]              read_index,
  // store access
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [ENTRY_W-1:0]            mem_wdata,
  output logic                          mem_re,
  // result of this item
  output res_ctl_t                      res_ctl,
  output logic [IDX_W-1:0]              res_index,
  output logic signed [SAMPLE_BITS-1:0] res_value,
  output logic [TIME_BITS-1:0]          res_time,
  output logic                          res_pos,
  output logic [CNT_W-1:0]              res_count
);

  localparam int CMP_W = ((SAMPLE_BITS > HYST_W) ? SAMPLE_BITS : HYST_W) + 2;
  localparam int EW    = (TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Configuration registers
  logic [HYST_W-1:0]             hyst_r;
  logic signed [SAMPLE_BITS-1:0] start_pos_r;
  logic signed [SAMPLE_BITS-1:0] start_neg_r;

  // Current peak state
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_val_r, cur_val_nxt;
  logic [TIME_BITS-1:0]          cur_time_r, cur_time_nxt;
  logic                          cur_pos_r, cur_pos_nxt;

  // Decision signals
  logic [EW-1:0]           el_wide;
  logic [TIME_BITS-1:0]    el;
  logic [TIME_BITS:0]      sum;
  logic [TIME_BITS-1:0]    ext_time;
  logic signed [CMP_W-1:0] vx, cx, hx;
  logic                    new_max, new_min, extend, full;
  logic [IDX_W-1:0]        last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r      <= HYST_W'(HYST_RST);
      start_pos_r <= SAMPLE_BITS'(START_POS_RST);
      start_neg_r <= SAMPLE_BITS'(START_NEG_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HYST:      hyst_r      <= cfg_data[HYST_W-1:0];
        CFG_START_POS: start_pos_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_START_NEG: start_neg_r <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      cur_val_r  <= '0;
      cur_time_r <= '0;
      cur_pos_r  <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      cur_val_r  <= cur_val_nxt;
      cur_time_r <= cur_time_nxt;
      cur_pos_r  <= cur_pos_nxt;
    end
  end

  // Elapsed clamp, saturating time sum and the peak comparisons
  always_comb begin
    el_wide = EW'(elapsed);
    el      = (el_wide > EW'(TIME_MAX)) ? TIME_MAX : el_wide[TIME_BITS-1:0];
    sum      = {1'b0, cur_time_r} + {1'b0, el};
    ext_time = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    vx = CMP_W'(sample);
    cx = CMP_W'(cur_val_r);
    hx = $signed(CMP_W'(hyst_r));
    new_max = 1'b0;
    new_min = 1'b0;
    extend  = 1'b0;
    if (count_r == '0) begin
      new_max = (sample >= start_pos_r);
      new_min = (sample < start_neg_r);
      if (new_max) begin
        new_min = 1'b0;
      end
    end else if (vx > cx) begin
      extend  = cur_pos_r;
      new_max = !cur_pos_r && (vx > cx + hx);
    end else begin
      extend  = !cur_pos_r;
      new_min = cur_pos_r && (vx < cx - hx);
    end
    full     = (count_r == CNT_W'(PEAK_DEPTH));
    last_idx = IDX_W'(count_r - CNT_W'(1));
  end

  // Next state, store access and result
  always_comb begin
    count_nxt    = count_r;
    cur_val_nxt  = cur_val_r;
    cur_time_nxt = cur_time_r;
    cur_pos_nxt  = cur_pos_r;
    mem_we       = 1'b0;
    mem_waddr    = count_r[IDX_W-1:0];
    mem_re       = 1'b0;
    res_ctl      = '{status: ST_IGNORED, rd_hit: 1'b0};
    res_index    = '0;
    res_value    = '0;
    res_time     = '0;
    res_pos      = 1'b0;

    unique case (operation)
      OP_READ: begin
        mem_re         = take;
        res_ctl.status = ST_READ;
        res_ctl.rd_hit = (CNT_W'(read_index) < count_r);
        res_index      = read_index;
      end
      OP_CLEAR: begin
        count_nxt      = '0;
        cur_val_nxt    = '0;
        cur_time_nxt   = '0;
        cur_pos_nxt    = 1'b0;
        res_ctl.status = ST_CLEARED;
      end
      OP_SAMPLE: begin
        if (extend) begin
          cur_val_nxt    = sample;
          cur_time_nxt   = ext_time;
          mem_we         = 1'b1;
          mem_waddr      = last_idx;
          res_ctl.status = ST_EXTEND;
          res_index      = last_idx;
          res_value      = sample;
          res_time       = ext_time;
          res_pos        = cur_pos_r;
        end else if (new_max || new_min) begin
          if (full) begin
            res_ctl.status = ST_FULL;
          end else begin
            count_nxt      = count_r + CNT_W'(1);
            cur_val_nxt    = sample;
            cur_time_nxt   = el;
            cur_pos_nxt    = new_max;
            mem_we         = 1'b1;
            res_ctl.status = ST_NEW;
            res_index      = count_r[IDX_W-1:0];
            res_value      = sample;
            res_time       = el;
            res_pos        = new_max;
          end
        end
      end
      default: ;
    endcase

    // Nothing changes unless an item is taken
    if (!take) begin
      count_nxt    = count_r;
      cur_val_nxt  = cur_val_r;
      cur_time_nxt = cur_time_r;
      cur_pos_nxt  = cur_pos_r;
      mem_we       = 1'b0;
    end
    res_count = count_nxt;
    mem_wdata = {cur_pos_nxt, cur_time_nxt, cur_val_nxt};
  end

endmodule

/* design/hysteresis_peak_tracker_top.sv */
// Top level of the hysteresis peak tracker: valid/ready channels, config port,
// peak store RAM and the result pipeline.
// Depends on hpt_pkg, hpt_if, hpt_ram and hpt_tracker.
//
// Usage:
//   Input items arrive on in_ch (operation, sample, elapsed, read_index) and
//   each one produces exactly one result on out_ch. A transfer happens on a
//   rising edge with valid and ready both high.
//   Sample items update the current peak and write new or extended peaks
//   into the peak store; read items fetch a store entry; clear restarts the
//   track (the store itself is kept, entries at or above the count read as zero).
//   An item transferred on in_ch is offered on out_ch after passing one stage
//   for the registered store read and then one output register. Throughput:
//   1/cycle while the receiver does not stall. The user writes registers through
//   cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//   Reset (rst_n low, synchronous) loads the register defaults, empties the
//   track and drops any item in flight; the store needs no clearing pass.
//   When the receiver stalls, the output register and one internal stage
//   fill up and in_ch.ready drops; nothing is lost or repeated.
module hysteresis_peak_tracker_top import hpt_pkg::*; #(
  parameter int PEAK_DEPTH  = PEAK_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  localparam int IDX_W      = $clog2(PEAK_DEPTH),
  localparam int CNT_W      = $clog2(PEAK_DEPTH + 1),
  localparam int CFG_W      = (SAMPLE_BITS > HYST_W) ? SAMPLE_BITS : HYST_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hpt_in_if.sink               in_ch,
  hpt_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int ENTRY_W = 1 + TIME_BITS + SAMPLE_BITS;

  logic                          take;
  logic                          advance;
  logic                          mem_we, mem_re;
  logic [IDX_W-1:0]              mem_waddr;
  logic [ENTRY_W-1:0]            mem_wdata, mem_rdata;
  res_ctl_t                      res_ctl;
  logic [IDX_W-1:0]              res_index;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic [TIME_BITS-1:0]          res_time;
  logic                          res_pos;
  logic [CNT_W-1:0]              res_count;

  // Stage after the store read
  logic                          s1_valid_r;
  res_ctl_t                      s1_ctl_r;
  logic [IDX_W-1:0]              s1_index_r;
  logic signed [SAMPLE_BITS-1:0] s1_value_r;
  logic [TIME_BITS-1:0]          s1_time_r;
  logic                          s1_pos_r;
  logic [CNT_W-1:0]              s1_count_r;

  // Output register
  logic                          out_valid_r;
  logic [STATUS_W-1:0]           out_status_r;
  logic [IDX_W-1:0]              out_index_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic [TIME_BITS-1:0]          out_time_r;
  logic                          out_pos_r;
  logic [CNT_W-1:0]              out_count_r;

  // Read-reply payload after the store lookup
  logic signed [SAMPLE_BITS-1:0] fin_value;
  logic [TIME_BITS-1:0]          fin_time;
  logic                          fin_pos;

  // Flow control
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  hpt_tracker #(
    .PEAK_DEPTH  (PEAK_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .operation  (in_ch.operation),
    .sample     (in_ch.sample),
    .elapsed    (in_ch.elapsed),
    .read_index (in_ch.read_index),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .res_ctl    (res_ctl),
    .res_index  (res_index),
    .res_value  (res_value),
    .res_time   (res_time),
    .res_pos    (res_pos),
    .res_count  (res_count)
  );

  // Peak store: {positive, time, value}
  hpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PEAK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (in_ch.read_index),
    .rdata (mem_rdata)
  );

  // Stage 1 register: result of the accepted item, store data pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctl_r   <= res_ctl;
      s1_index_r <= res_index;
      s1_value_r <= res_value;
      s1_time_r  <= res_time;
      s1_pos_r   <= res_pos;
      s1_count_r <= res_count;
    end
  end

  // Read replies take their payload from the store when the entry is held
  always_comb begin
    fin_value = s1_value_r;
    fin_time  = s1_time_r;
    fin_pos   = s1_pos_r;
    if (s1_ctl_r.status == ST_READ) begin
      if (s1_ctl_r.rd_hit) begin
        fin_value = mem_rdata[SAMPLE_BITS-1:0];
        fin_time  = mem_rdata[SAMPLE_BITS +: TIME_BITS];
        fin_pos   = mem_rdata[ENTRY_W-1];
      end else begin
        fin_value = '0;
        fin_time  = '0;
        fin_pos   = 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_status_r <= s1_ctl_r.status;
      out_index_r  <= s1_index_r;
      out_value_r  <= fin_value;
      out_time_r   <= fin_time;
      out_pos_r    <= fin_pos;
      out_count_r  <= s1_count_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.peak_index    = out_index_r;
  assign out_ch.peak_value    = out_value_r;
  assign out_ch.peak_time     = out_time_r;
  assign out_ch.peak_positive = out_pos_r;
  assign out_ch.peak_count    = out_count_r;

endmodule

/* tb/tb_top.sv */
// Testbench for the hysteresis peak tracker. Drives items over valid/ready
// with random sender gaps and receiver stalls and checks every result against
// a peak-tracking predictor kept in the bench. Depends on hpt_pkg, hpt_if and the RTL.
module tb_top;
  import hpt_pkg::*;

  localparam int SW    = SAMPLE_BITS_DEF;
  localparam int TW    = TIME_BITS_DEF;
  localparam int DEPTH = PEAK_DEPTH_DEF;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CFG_W = (SW > HYST_W) ? SW : HYST_W;
  localparam int SMIN  = -(2 ** (SW - 1));
  localparam int SMAX  = 2 ** (SW - 1) - 1;
  localparam int IMAX  = DEPTH - 1;
  localparam int EMAX  = 2 ** ELAPSED_W - 1;
  localparam int HMAX  = 2 ** HYST_W - 1;
  localparam int WATCHDOG_LIMIT = 1000;

  // operation code the block does not define; it must come back ignored
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SW-1:0] val;
    logic [TW-1:0]        tim;
    logic                 pos;
  } peak_rec_t;

  typedef struct packed {
    status_t              status;
    logic [IW-1:0]        idx;
    logic signed [SW-1:0] val;
    logic [TW-1:0]        tim;
    logic                 pos;
    logic [CW-1:0]        cnt;
  } peak_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  hpt_in_if  in_ch ();
  hpt_out_if out_ch ();

  hysteresis_peak_tracker_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Tracker state as the bench predicts it
  logic [HYST_W-1:0]    hyst_q  = HYST_W'(HYST_RST);
  logic signed [SW-1:0] lvl_pos = SW'(START_POS_RST);
  logic signed [SW-1:0] lvl_neg = SW'(START_NEG_RST);
  logic [CW-1:0]        n_peaks = '0;
  logic signed [SW-1:0] cur_val = '0;
  logic [TW-1:0]        cur_time = '0;
  logic                 cur_pos = 1'b0;
  peak_rec_t            peak_mem [DEPTH];

  peak_result_t results_due[$];
  int           mismatches = 0;
  int           idle_cycles = 0;

  // Sender burst/gap state
  int      burst_left = 0;
  bit      gaps_on = 1'b1;
  bit      tx_held = 1'b0;
  status_t last_status;

  // Receiver stall pattern state
  int rx_mode = 0;
  int rx_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict the result of one accepted item and advance the tracker state
  function automatic peak_result_t track_item(logic [OP_W-1:0] op, logic signed [SW-1:0] smp,
                                              logic [ELAPSED_W-1:0] el, logic [IW-1:0] ri);
    peak_result_t r;
    int v, c, h;
    bit grow, open, new_pos;
    logic [TW:0] sum;
    r = '0;
    grow = 1'b0;
    open = 1'b0;
    new_pos = 1'b0;
    case (op)
      OP_READ: begin
        r.status = ST_READ;
        r.idx = ri;
        if (ri < n_peaks) begin
          r.val = peak_mem[ri].val;
          r.tim = peak_mem[ri].tim;
          r.pos = peak_mem[ri].pos;
        end
      end
      OP_CLEAR: begin
        n_peaks = '0;
        cur_val = '0;
        cur_time = '0;
        cur_pos = 1'b0;
        r.status = ST_CLEARED;
      end
      OP_SAMPLE: begin
        v = smp;
        c = cur_val;
        h = hyst_q;
        if (n_peaks == 0) begin
          if (v >= int'(lvl_pos)) begin
            open = 1'b1;
            new_pos = 1'b1;
          end else if (v < int'(lvl_neg)) begin
            open = 1'b1;
          end
        end else if (v > c) begin
          if (cur_pos) grow = 1'b1;
          else if (v - h > c) begin
            open = 1'b1;
            new_pos = 1'b1;
          end
        end else begin
          if (!cur_pos) grow = 1'b1;
          else if (v + h < c) open = 1'b1;
        end

        if (grow) begin
          // extension: time accumulates and saturates
          sum = {1'b0, cur_time} + (TW + 1)'(el);
          cur_time = sum[TW] ? '1 : sum[TW-1:0];
          cur_val = smp;
          peak_mem[n_peaks - 1] = '{cur_val, cur_time, cur_pos};
          r = '{ST_EXTEND, IW'(n_peaks - 1), cur_val, cur_time, cur_pos, '0};
        end else if (open) begin
          if (n_peaks >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            cur_val = smp;
            cur_time = TW'(el);
            cur_pos = new_pos;
            peak_mem[n_peaks] = '{cur_val, cur_time, cur_pos};
            n_peaks = n_peaks + 1;
            r = '{ST_NEW, IW'(n_peaks - 1), cur_val, cur_time, cur_pos, '0};
          end
        end
      end
      default: ;  // unknown code is ignored
    endcase
    r.cnt = n_peaks;
    return r;
  endfunction

  function automatic int rand_in(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_sample(int v);
    if (v < SMIN) return SMIN;
    if (v > SMAX) return SMAX;
    return v;
  endfunction

  // Sample that mostly follows the track: extend, reverse, or stay in the band
  function automatic int pick_sample();
    int c, h, r, lo, hi;
    c = cur_val;
    h = hyst_q;
    r = $urandom_range(0, 99);
    if (r < 15) return rand_in(SMIN, SMAX);
    if (n_peaks == 0) begin
      if (r < 55 || int'(lvl_neg) == SMIN) return rand_in(int'(lvl_pos), SMAX);
      return rand_in(SMIN, int'(lvl_neg) - 1);
    end
    if (r < 55) return cur_pos ? rand_in(c, clamp_sample(c + 150)) : rand_in(clamp_sample(c - 150), c);
    if (r < 85) begin
      if (cur_pos) begin
        hi = clamp_sample(c - h - 1);
        return rand_in(clamp_sample(hi - 200), hi);
      end
      lo = clamp_sample(c + h + 1);
      return rand_in(lo, clamp_sample(lo + 200));
    end
    return cur_pos ? rand_in(clamp_sample(c - h), c) : rand_in(c, clamp_sample(c + h));
  endfunction

  function automatic int pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return EMAX - int'($urandom_range(0, 20));
    if (r < 40) return $urandom_range(0, EMAX);
    return $urandom_range(0, 500);
  endfunction

  function automatic int pick_read_index();
    if (n_peaks != 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, n_peaks - 1);
    return $urandom_range(0, IMAX);
  endfunction

  // Drop valid; called at a falling edge
  task automatic sender_idle();
    if (tx_held) in_ch.valid <= 1'b0;
    tx_held = 1'b0;
    burst_left = 0;
  endtask

  // One input transfer; entered and left at a falling edge
  task automatic send_item(logic [OP_W-1:0] op, int smp, int el, int ri);
    logic signed [SW-1:0] s;
    logic [ELAPSED_W-1:0] e;
    logic [IW-1:0] idx;
    int gap;
    peak_result_t exp_res;
    s = SW'(smp);
    e = ELAPSED_W'(el);
    idx = IW'(ri);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        if (tx_held) in_ch.valid <= 1'b0;
        tx_held = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.sample     <= s;
    in_ch.elapsed    <= e;
    in_ch.read_index <= idx;
    tx_held = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_res = track_item(op, s, e, idx);
    last_status = exp_res.status;
    results_due.push_back(exp_res);
    @(negedge clk);
  endtask

  // Sender holds off until every expected result is back
  task automatic wait_results_drained();
    sender_idle();
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Write all three registers while the block is idle
  task automatic set_thresholds(int h, int p, int n);
    wait_results_drained();
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HYST;
    cfg_data  <= CFG_W'(h);
    @(negedge clk);
    cfg_index <= CFG_START_POS;
    cfg_data  <= CFG_W'(p);
    @(negedge clk);
    cfg_index <= CFG_START_NEG;
    cfg_data  <= CFG_W'(n);
    @(negedge clk);
    cfg_we <= 1'b0;
    hyst_q  = HYST_W'(h);
    lvl_pos = SW'(p);
    lvl_neg = SW'(n);
  endtask

  // Start thresholds, equal samples, time saturation, reads and clear
  task automatic test_directed_cases();
    send_item(OP_SAMPLE, 99, 0, 0);            // between start levels
    send_item(OP_SAMPLE, -100, EMAX, 0);       // exactly on negative level
    send_item(OP_READ, 0, 0, 0);               // read with empty track
    send_item(OP_READ, 0, 0, IMAX);
    send_item(OP_UNUSED, SMIN, EMAX, IMAX);
    send_item(OP_SAMPLE, 100, EMAX, 0);        // first maximum on the level
    send_item(OP_SAMPLE, 100, 5, 0);           // equal sample, maximum ignores
    send_item(OP_SAMPLE, SMAX, 1, 0);          // extend, time saturates
    send_item(OP_SAMPLE, SMAX - 30, 7, 0);     // inside the band
    send_item(OP_SAMPLE, SMAX - 31, 40000, 0); // new minimum
    send_item(OP_SAMPLE, SMAX - 31, 20000, 0); // equal sample extends minimum
    send_item(OP_SAMPLE, SMIN, 0, 0);
    send_item(OP_SAMPLE, SMIN + 30, 3, 0);     // not past the band
    send_item(OP_SAMPLE, SMIN + 31, EMAX, 0);  // new maximum
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 0, 0, 1);
    send_item(OP_READ, 0, 0, 2);
    send_item(OP_READ, 0, 0, 3);               // beyond the count
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0);               // cleared entries read as zero
    send_item(OP_SAMPLE, -101, 12, 0);         // first peak a minimum
    send_item(OP_SAMPLE, 0, 9, 0);
    send_item(OP_READ, 0, 0, 1);
    send_item(OP_CLEAR, SMAX, EMAX, IMAX);
  endtask

  // Fill the whole store, then push against the full condition
  task automatic test_store_full();
    int c, v;
    set_thresholds(0, START_POS_RST, START_NEG_RST);
    send_item(OP_CLEAR, 0, 0, 0);
    while (n_peaks < DEPTH) begin
      c = cur_val;
      if (n_peaks == 0) v = rand_in(START_POS_RST, SMAX);
      else if ($urandom_range(0, 9) == 0) v = cur_pos ? rand_in(c, SMAX) : rand_in(SMIN, c);
      else v = cur_pos ? rand_in(SMIN, c - 1) : rand_in(c + 1, SMAX);
      send_item(OP_SAMPLE, v, pick_elapsed(), $urandom_range(0, IMAX));
    end
    repeat (40) begin
      if ($urandom_range(0, 2) == 0)
        send_item(OP_READ, $urandom_range(0, 2 * SMAX + 1), $urandom_range(0, EMAX),
                  pick_read_index());
      else
        send_item(OP_SAMPLE, pick_sample(), pick_elapsed(), $urandom_range(0, IMAX));
    end
    send_item(OP_READ, 0, 0, IMAX);
    send_item(OP_CLEAR, 0, 0, 0);
  endtask

  // One stretch of mostly well-formed traffic under the current thresholds
  task automatic run_tracking_phase(int n, bit gaps);
    int counted, r;
    gaps_on = gaps;
    counted = 0;
    send_item(OP_CLEAR, $urandom_range(0, 2 * SMAX + 1), $urandom_range(0, EMAX),
              $urandom_range(0, IMAX));
    while (counted < n) begin
      r = $urandom_range(0, 99);
      if (r < 72)
        send_item(OP_SAMPLE, pick_sample(), pick_elapsed(), $urandom_range(0, IMAX));
      else if (r < 90)
        send_item(OP_READ, $urandom_range(0, 2 * SMAX + 1), $urandom_range(0, EMAX),
                  pick_read_index());
      else if (r < 93)
        send_item(OP_CLEAR, $urandom_range(0, 2 * SMAX + 1), $urandom_range(0, EMAX),
                  $urandom_range(0, IMAX));
      else if (r < 95)
        send_item(OP_UNUSED, $urandom_range(0, 2 * SMAX + 1), $urandom_range(0, EMAX),
                  $urandom_range(0, IMAX));
      else
        send_item(OP_SAMPLE, rand_in(SMIN, SMAX), $urandom_range(0, EMAX),
                  $urandom_range(0, IMAX));
      if (last_status != ST_IGNORED) counted++;
    end
  endtask

  task automatic test_random_tracking();
    set_thresholds(HMAX, SMIN, SMIN);
    run_tracking_phase(55, 1'b1);
    set_thresholds(0, SMAX, SMIN);
    run_tracking_phase(55, 1'b1);
    set_thresholds($urandom_range(0, 200), rand_in(SMIN, SMAX), rand_in(SMIN, SMAX));
    run_tracking_phase(55, 1'b0);
    set_thresholds(5, SMIN, SMAX);
    run_tracking_phase(55, 1'b1);
    set_thresholds(HYST_RST, START_POS_RST, START_NEG_RST);
    run_tracking_phase(55, 1'b0);
  endtask

  // Receiver: modes of random length, from always ready to mostly stalled
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 80);
    end
    rx_left--;
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 1);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (rx_left % 3 != 0);
    endcase
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker: each result transfer against the oldest expectation
  always @(posedge clk) begin
    peak_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with no item outstanding");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("peak_index", want.idx, out_ch.peak_index);
        check_field("peak_value", want.val, out_ch.peak_value);
        check_field("peak_time", want.tim, out_ch.peak_time);
        check_field("peak_positive", want.pos, out_ch.peak_positive);
        check_field("peak_count", want.cnt, out_ch.peak_count);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_SAMPLE;
    in_ch.sample     = '0;
    in_ch.elapsed    = '0;
    in_ch.read_index = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_HYST;
    cfg_data         = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_store_full();
    test_random_tracking();

    wait_results_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/hpt_pkg.sv
design/hpt_if.sv
design/hpt_ram.sv
design/hpt_tracker.sv
design/hysteresis_peak_tracker_top.sv
tb/tb_top.sv
